@@ hw/rtl/cftm_pkg.sv @@
// ----------------------------------------------------------------------------
// cftm_pkg
// Shared types and constants of the cpu frequency throttle monitor: field
// widths, stream packing offsets, register codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cftm_pkg;

    // field widths
    localparam int CIDX_W     = 3;
    localparam int CYC_W      = 64;
    localparam int WIN_W      = 40;
    localparam int FREQ_W     = 24;
    localparam int TS_W       = 64;
    localparam int CAP_W      = 11;
    localparam int MINWIN_W   = 20;
    localparam int LAT_W      = 30;
    localparam int SIM_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 30;

    // capacity scale is 1024, applied as a shift
    localparam int CAP_SHIFT = 10;
    localparam logic [CAP_W-1:0] CAP_FULL = CAP_W'(1024);

    // register reset values
    localparam logic [MINWIN_W-1:0] MINWIN_RST = MINWIN_W'(3000);
    localparam logic [LAT_W-1:0]    LAT_RST    = LAT_W'(500000);
    localparam logic [SIM_W-1:0]    SIM_RST    = SIM_W'(1078);

    // input tdata layout, lowest field first
    localparam int IN_CIDX_LSB = 0;
    localparam int IN_ONL_LSB  = IN_CIDX_LSB + CIDX_W;
    localparam int IN_CYC_LSB  = IN_ONL_LSB + 1;
    localparam int IN_WIN_LSB  = IN_CYC_LSB + CYC_W;
    localparam int IN_TGT_LSB  = IN_WIN_LSB + WIN_W;
    localparam int IN_MAX_LSB  = IN_TGT_LSB + FREQ_W;
    localparam int IN_NOW_LSB  = IN_MAX_LSB + FREQ_W;
    localparam int IN_BITS     = IN_NOW_LSB + TS_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout, lowest field first
    localparam int OUT_TAKEN_LSB = 0;
    localparam int OUT_MEAS_LSB  = OUT_TAKEN_LSB + 1;
    localparam int OUT_SVAL_LSB  = OUT_MEAS_LSB + FREQ_W;
    localparam int OUT_SCALE_LSB = OUT_SVAL_LSB + 1;
    localparam int OUT_THR_LSB   = OUT_SCALE_LSB + CAP_W;
    localparam int OUT_CVAL_LSB  = OUT_THR_LSB + 1;
    localparam int OUT_CAP_LSB   = OUT_CVAL_LSB + 1;
    localparam int OUT_BITS      = OUT_CAP_LSB + CAP_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // shared divider operand widths
    localparam int DVD_W = CYC_W;
    localparam int DVS_W = WIN_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_WINDOW = 2'd0,
        CFG_LATENCY    = 2'd1,
        CFG_SIMILARITY = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_MEAS,
        S_CLAMP,
        S_COMPARE,
        S_DETECT,
        S_DIV_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic start_meas_div;
        logic latch_meas;
        logic latch_cmp;
        logic update_det;
        logic start_scale_div;
        logic latch_scale;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic div_busy;
        logic div_done;
        logic meas_zero;
        logic need_scale_div;
    } t_status;

endpackage

@@ hw/rtl/cpu_frequency_throttle_monitor.sv @@
// ----------------------------------------------------------------------------
// cpu_frequency_throttle_monitor
// Per-core frequency measurement, frequency scale and throttle detection
// from cycle count samples.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  s_axis_tdata (sample)
//   m_axis    out        m_axis_tvalid / m_axis_tready  m_axis_tdata (result)
//   cfg       in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One sample at a time; the time from acceptance to result is set mostly by
// the shared restoring divider, one quotient bit per cycle over 64 bits,
// used twice when the frequency scale needs a division, once when it does
// not, and not at all when the sample is rejected.
// Reset (synchronous, active low) clears the per-core throttle state and
// loads the register defaults. The next sample is taken while a result
// still waits in the output register; a stalled output holds the controller
// only once a second result is ready.
// ----------------------------------------------------------------------------
module cpu_frequency_throttle_monitor #(
    parameter int NUM_CORES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // core_index[2:0], core_online[3], scaled_cycles[67:4], window_ns[107:68],
    // target_khz[131:108], max_khz[155:132], now_ns[219:156], zero fill
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cftm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // sample_taken[0], meas_khz[24:1], scale_valid[25], freq_ratio[36:26],
    // throttled[37], capacity_valid[38], capacity[49:39], zero fill
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cftm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cftm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cftm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cftm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_state  w_state;

    assign o_cfg_ready = 1'b1;

    cftm_dp #(
        .NUM_CORES (NUM_CORES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_tdata  (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_tdata (m_axis_tdata)
    );

    cftm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    // a new sample never lands while the divider is still working
    a_load_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_in |-> !w_status.div_busy)
        else $error("sample loaded while divider busy");

    // divider completion is only seen while the controller waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.div_done |-> (w_state == S_DIV_MEAS || w_state == S_DIV_SCALE))
        else $error("divider done outside a division state");

    // a loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> m_axis_tvalid)
        else $error("result loaded but not valid");

    // a rejected sample carries an all-zero result
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[OUT_TAKEN_LSB])
            |-> m_axis_tdata[OUT_BITS-1:OUT_MEAS_LSB] == '0)
        else $error("rejected sample with nonzero result fields");

endmodule

@@ hw/rtl/cftm_div.sv @@
// ----------------------------------------------------------------------------
// cftm_div
// Restoring divider, one quotient bit per cycle. Shared by the frequency
// measurement and the frequency scale division.
// ----------------------------------------------------------------------------
module cftm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cftm_pkg::DVD_W-1:0]  i_dividend,
    input  logic [cftm_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [cftm_pkg::DVD_W-1:0]  o_quotient
);
    import cftm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_divisor;
    logic [DVD_W-1:0] r_work;

    logic [DVS_W:0]   w_rem_shift;
    logic             w_fits;
    logic [DVS_W:0]   w_rem_sub;
    logic [DVS_W-1:0] n_rem;

    // work register holds the remaining dividend bits on top, quotient below
    always_comb begin
        w_rem_shift = {r_rem, r_work[DVD_W-1]};
        w_fits      = w_rem_shift >= {1'b0, r_divisor};
        w_rem_sub   = w_rem_shift - {1'b0, r_divisor};
        n_rem       = w_fits ? w_rem_sub[DVS_W-1:0] : w_rem_shift[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_work    <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= {r_work[DVD_W-2:0], w_fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

@@ hw/rtl/cftm_dp.sv @@
// ----------------------------------------------------------------------------
// cftm_dp
// Datapath: configuration registers, sample registers, the shared divider,
// the per-core throttle detector state and the result register.
// ----------------------------------------------------------------------------
module cftm_dp #(
    parameter int NUM_CORES = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cftm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cftm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [cftm_pkg::IN_TDATA_W-1:0]   i_in_tdata,
    input  cftm_pkg::t_cmd                    i_cmd,
    output cftm_pkg::t_status                 o_status,
    output logic [cftm_pkg::OUT_TDATA_W-1:0]  o_out_tdata
);
    import cftm_pkg::*;

    localparam int CORE_SEL_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int SEL_EXT_W  = (CORE_SEL_W > CIDX_W) ? CORE_SEL_W : CIDX_W;
    localparam int PROD_W     = FREQ_W + SIM_W;

    // configuration
    logic [MINWIN_W-1:0] r_min_window;
    logic [LAT_W-1:0]    r_latency;
    logic [SIM_W-1:0]    r_similarity;

    // sample
    logic [CIDX_W-1:0] r_core_index;
    logic              r_online;
    logic [CYC_W-1:0]  r_cycles;
    logic [WIN_W-1:0]  r_window;
    logic [FREQ_W-1:0] r_target;
    logic [FREQ_W-1:0] r_max;
    logic [TS_W-1:0]   r_now;

    // intermediate results
    logic              r_taken;
    logic [FREQ_W-1:0] r_meas;
    logic              r_below;
    logic              r_elapsed_ge;
    logic              r_meas_lt_max;
    logic              r_thr;
    logic [CAP_W-1:0]  r_scale;
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    // per-core detector state
    logic [TS_W-1:0]      r_start [NUM_CORES];
    logic [NUM_CORES-1:0] r_running;
    logic [NUM_CORES-1:0] r_flag;

    logic                  w_core_ok;
    logic [SEL_EXT_W-1:0]  w_core_ext;
    logic [CORE_SEL_W-1:0] w_core_sel;
    logic [DVD_W-1:0]      w_dividend;
    logic [DVS_W-1:0]      w_divisor;
    logic                  w_div_busy;
    logic                  w_div_done;
    logic [DVD_W-1:0]      w_quot;
    logic [FREQ_W-1:0]     w_meas_sat;
    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W-1:0]     w_target_scaled;
    logic [TS_W-1:0]       w_start_eff;
    logic [TS_W-1:0]       w_elapsed;
    logic                  w_max_known;
    logic [CAP_W-1:0]      w_scale_out;
    logic [OUT_TDATA_W-1:0] n_out_tdata;

    always_comb begin
        w_core_ext = SEL_EXT_W'(r_core_index);
        w_core_sel = w_core_ext[CORE_SEL_W-1:0];
        w_core_ok  = int'(r_core_index) < NUM_CORES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_window <= MINWIN_RST;
            r_latency    <= LAT_RST;
            r_similarity <= SIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_WINDOW: r_min_window <= i_cfg_data[MINWIN_W-1:0];
                CFG_LATENCY:    r_latency    <= i_cfg_data[LAT_W-1:0];
                CFG_SIMILARITY: r_similarity <= i_cfg_data[SIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_core_index <= i_in_tdata[IN_CIDX_LSB +: CIDX_W];
            r_online     <= i_in_tdata[IN_ONL_LSB];
            r_cycles     <= i_in_tdata[IN_CYC_LSB +: CYC_W];
            r_window     <= i_in_tdata[IN_WIN_LSB +: WIN_W];
            r_target     <= i_in_tdata[IN_TGT_LSB +: FREQ_W];
            r_max        <= i_in_tdata[IN_MAX_LSB +: FREQ_W];
            r_now        <= i_in_tdata[IN_NOW_LSB +: TS_W];
        end
    end

    // divider operands: cycles / window first, then (meas * 1024) / max
    always_comb begin
        w_dividend = i_cmd.start_scale_div ? DVD_W'({r_meas, {CAP_SHIFT{1'b0}}}) : r_cycles;
        w_divisor  = i_cmd.start_scale_div ? DVS_W'(r_max) : r_window;
    end

    cftm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_meas_div | i_cmd.start_scale_div),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        w_meas_sat      = (|w_quot[DVD_W-1:FREQ_W]) ? '1 : w_quot[FREQ_W-1:0];
        w_prod          = PROD_W'(r_meas) * PROD_W'(r_similarity);
        w_target_scaled = PROD_W'({r_target, {CAP_SHIFT{1'b0}}});
        w_start_eff     = r_running[w_core_sel] ? r_start[w_core_sel] : r_now;
        w_elapsed       = r_now - w_start_eff;
        w_max_known     = r_max != '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= 1'b0;
        end else if (i_cmd.load_in) begin
            r_taken <= 1'b0;
        end else if (i_cmd.latch_meas) begin
            r_taken <= w_quot != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_meas) begin
            r_meas <= w_meas_sat;
        end
        if (i_cmd.latch_cmp) begin
            r_below       <= w_prod < w_target_scaled;
            r_elapsed_ge  <= w_elapsed >= TS_W'(r_latency);
            r_meas_lt_max <= r_meas < r_max;
        end
        if (i_cmd.latch_scale) begin
            r_scale <= w_quot[CAP_W-1:0];
        end
    end

    // throttle detector: timer, flag and decision for the sampled core
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_flag    <= '0;
        end else if (i_cmd.update_det && r_target != '0) begin
            if (r_below) begin
                r_running[w_core_sel] <= 1'b1;
                if (r_elapsed_ge) begin
                    r_flag[w_core_sel] <= 1'b1;
                end
            end else begin
                r_running[w_core_sel] <= 1'b0;
                r_flag[w_core_sel]    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update_det) begin
            if (r_target == '0) begin
                r_thr <= 1'b0;
            end else if (r_below) begin
                if (!r_running[w_core_sel]) begin
                    r_start[w_core_sel] <= r_now;
                end
                r_thr <= r_elapsed_ge | r_flag[w_core_sel];
            end else begin
                r_start[w_core_sel] <= '0;
                r_thr               <= 1'b0;
            end
        end
    end

    // scale and capacity are both 1024 once measured reaches max
    always_comb begin
        w_scale_out = r_meas_lt_max ? r_scale : CAP_FULL;
        n_out_tdata = '0;
        if (r_taken) begin
            n_out_tdata[OUT_TAKEN_LSB]          = 1'b1;
            n_out_tdata[OUT_MEAS_LSB +: FREQ_W] = r_meas;
            if (w_max_known) begin
                n_out_tdata[OUT_SVAL_LSB]           = 1'b1;
                n_out_tdata[OUT_SCALE_LSB +: CAP_W] = w_scale_out;
            end
            n_out_tdata[OUT_THR_LSB] = r_thr;
            if (r_thr && w_max_known) begin
                n_out_tdata[OUT_CVAL_LSB]         = 1'b1;
                n_out_tdata[OUT_CAP_LSB +: CAP_W] = w_scale_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_tdata <= n_out_tdata;
        end
    end

    always_comb begin
        o_status.reject         = !r_online || !w_core_ok || r_window == '0
                                  || r_window < WIN_W'(r_min_window);
        o_status.div_busy       = w_div_busy;
        o_status.div_done       = w_div_done;
        o_status.meas_zero      = w_quot == '0;
        o_status.need_scale_div = w_max_known && r_meas_lt_max;
    end

    assign o_out_tdata = r_out_tdata;

endmodule

@@ hw/rtl/cftm_ctrl.sv @@
// ----------------------------------------------------------------------------
// cftm_ctrl
// Controller: sequences check, measurement division, detector update and
// scale division for one sample, and owns the result valid flag.
// ----------------------------------------------------------------------------
module cftm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  cftm_pkg::t_status i_status,
    output cftm_pkg::t_cmd    o_cmd,
    output cftm_pkg::t_state  o_state
);
    import cftm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.reject) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.start_meas_div = 1'b1;
                    n_state              = S_DIV_MEAS;
                end
            end
            S_DIV_MEAS: begin
                if (i_status.div_done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                o_cmd.latch_meas = 1'b1;
                n_state = i_status.meas_zero ? S_DONE : S_COMPARE;
            end
            S_COMPARE: begin
                o_cmd.latch_cmp = 1'b1;
                n_state         = S_DETECT;
            end
            S_DETECT: begin
                o_cmd.update_det = 1'b1;
                if (i_status.need_scale_div) begin
                    o_cmd.start_scale_div = 1'b1;
                    n_state               = S_DIV_SCALE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV_SCALE: begin
                if (i_status.div_done) begin
                    o_cmd.latch_scale = 1'b1;
                    n_state           = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_state     = r_state;

endmodule
